FILE: src/usp_pkg.sv
package usp_pkg;

  // Entry index width; covers the largest table the top level supports.
  localparam int SLOT_W = 8;

  localparam logic [2:0] OP_OPEN   = 3'd0;
  localparam logic [2:0] OP_CLOSE  = 3'd1;
  localparam logic [2:0] OP_BIND   = 3'd2;
  localparam logic [2:0] OP_LOOKUP = 3'd3;
  localparam logic [2:0] OP_PREP   = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_BAD_ID   = 3'd2;
  localparam logic [2:0] ST_IN_USE   = 3'd3;
  localparam logic [2:0] ST_NO_MATCH = 3'd4;
  localparam logic [2:0] ST_NO_ROUTE = 3'd5;
  localparam logic [2:0] ST_NO_PORT  = 3'd6;

  localparam logic CFG_EPH_MIN = 1'b0;
  localparam logic CFG_EPH_MAX = 1'b1;

  localparam logic [15:0] EPH_MIN_RESET = 16'd49152;
  localparam logic [15:0] EPH_MAX_RESET = 16'd65535;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  socket_id;
    logic [31:0] ip_address;
    logic [15:0] port_number;
    logic [31:0] route_address;
  } usp_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  result_id;
    logic [31:0] local_address;
    logic [15:0] local_port;
  } usp_rsp_t;

  // Query that travels down the row of entry cells, one cell per cycle.
  typedef struct packed {
    logic              valid;
    logic              find_free;
    logic [3:0]        id;
    logic [31:0]       addr;
    logic [15:0]       port;
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic              id_open;
    logic [31:0]       id_addr;
    logic [15:0]       id_port;
  } usp_tok_t;

  typedef enum logic [1:0] {
    WR_OPEN,
    WR_CLOSE,
    WR_BIND,
    WR_PORT
  } usp_wr_kind_t;

  typedef struct packed {
    logic              en;
    usp_wr_kind_t      kind;
    logic [SLOT_W-1:0] idx;
    logic [31:0]       addr;
    logic [15:0]       port;
  } usp_wr_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_SCAN,
    S_FINISH
  } usp_state_t;

endpackage

FILE: src/udp_socket_port_table_unit.sv
// UDP socket port table.
// Request channel (req_valid/req_stall/req): one word per operation: open,
// close, bind, lookup or prepare send. Response channel (rsp_valid/rsp_stall/
// rsp): exactly one word per request, in order. Config channel (cfg_valid/
// cfg_ready, always ready): index 0 sets the first ephemeral port, index 1
// the last; write only while the block is idle.
// Entries live in a row of TABLE_ENTRIES cells; each query word moves one
// cell per cycle through the row. Open, close, bind and lookup take one
// pass, and the next request can be accepted once the response is loaded.
// Prepare send that must pick a port adds a scan that issues up to
// TABLE_ENTRIES + 1 candidate ports back to back (fewer for a shorter range
// or once a free port comes back) and waits for them to drain.
// One request is in flight at a time; req_stall is high from accept until
// the response is loaded into the output register. A stalled response holds
// in that register while the next request is already accepted; that
// request's response waits, with req_stall high, until the register frees.
// Synchronous reset frees every entry, clears addresses and ports, and
// restores the port range to 49152..65535.
module udp_socket_port_table_unit #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  usp_pkg::usp_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output usp_pkg::usp_rsp_t rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data
);
  import usp_pkg::*;

  usp_tok_t chain [TABLE_ENTRIES+1];
  usp_wr_t  wr;

  usp_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (chain[0]),
    .tail      (chain[TABLE_ENTRIES]),
    .wr        (wr)
  );

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    usp_cell #(
      .SLOT(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (chain[i]),
      .wr      (wr),
      .tok_out (chain[i+1])
    );
  end

endmodule

FILE: src/usp_cell.sv
module usp_cell #(
  parameter int SLOT = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  usp_pkg::usp_tok_t tok_in,
  input  usp_pkg::usp_wr_t  wr,
  output usp_pkg::usp_tok_t tok_out
);
  import usp_pkg::*;

  localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(SLOT);

  logic        open;
  logic [31:0] addr;
  logic [15:0] port;
  logic        match;
  usp_tok_t    tok_next;

  always_comb begin
    if (tok_in.find_free) begin
      match = !open;
    end else begin
      match = open && (addr == 32'd0 || tok_in.addr == 32'd0 || addr == tok_in.addr) &&
              port == tok_in.port;
    end
    tok_next = tok_in;
    if ({{(SLOT_W-4){1'b0}}, tok_in.id} == MY_IDX) begin
      tok_next.id_open = open;
      tok_next.id_addr = addr;
      tok_next.id_port = port;
    end
    // First hit wins: lower cells see the word earlier.
    if (!tok_in.hit && match) begin
      tok_next.hit     = 1'b1;
      tok_next.hit_idx = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open <= 1'b0;
      addr <= 32'd0;
      port <= 16'd0;
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
      if (wr.en && wr.idx == MY_IDX) begin
        case (wr.kind)
          WR_OPEN: open <= 1'b1;
          WR_CLOSE: begin
            open <= 1'b0;
            addr <= 32'd0;
            port <= 16'd0;
          end
          WR_BIND: begin
            addr <= wr.addr;
            port <= wr.port;
          end
          WR_PORT: port <= wr.port;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: src/usp_ctrl.sv
module usp_ctrl #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  usp_pkg::usp_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output usp_pkg::usp_rsp_t rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  output usp_pkg::usp_tok_t head,
  input  usp_pkg::usp_tok_t tail,
  output usp_pkg::usp_wr_t  wr
);
  import usp_pkg::*;

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 2);
  localparam logic [CNT_W-1:0] MAX_TRIES = CNT_W'(TABLE_ENTRIES + 1);

  usp_state_t state, state_next;

  logic [15:0]      eph_min;
  logic [15:0]      eph_max;
  usp_req_t         item, item_next;
  usp_tok_t         head_next;
  logic [31:0]      src, src_next;
  logic [16:0]      cand, cand_next;
  logic [CNT_W-1:0] inj_cnt, inj_cnt_next;
  logic [CNT_W-1:0] ret_cnt, ret_cnt_next;
  logic             found, found_next;
  logic [15:0]      chosen, chosen_next;
  usp_rsp_t         res, res_next;
  usp_wr_t          wr_pend, wr_pend_next;

  logic        out_free;
  logic        out_load;
  logic        can_inject;
  logic        scan_done;
  logic [31:0] probe_src;
  logic        need_scan;

  assign cfg_ready  = 1'b1;
  assign out_free   = !rsp_valid || !rsp_stall;
  assign can_inject = !found && inj_cnt < MAX_TRIES && cand <= {1'b0, eph_max};
  assign scan_done  = !can_inject && ret_cnt == inj_cnt;
  assign probe_src  = (tail.id_addr != 32'd0) ? tail.id_addr : item.route_address;
  assign need_scan  = item.opcode == OP_PREP && tail.id_open && probe_src != 32'd0 &&
                      tail.id_port == 16'd0;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (req_valid) state_next = S_PROBE;
      S_PROBE:  if (tail.valid) state_next = need_scan ? S_SCAN : S_FINISH;
      S_SCAN:   if (scan_done) state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_stall    = (state != S_IDLE);
    out_load     = 1'b0;
    wr           = '0;
    head_next    = '0;
    item_next    = item;
    src_next     = src;
    cand_next    = cand;
    inj_cnt_next = inj_cnt;
    ret_cnt_next = ret_cnt;
    found_next   = found;
    chosen_next  = chosen;
    res_next     = res;
    wr_pend_next = wr_pend;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          item_next           = req;
          head_next.valid     = 1'b1;
          head_next.find_free = (req.opcode == OP_OPEN);
          head_next.id        = req.socket_id;
          head_next.addr      = req.ip_address;
          head_next.port      = req.port_number;
        end
      end
      S_PROBE: begin
        if (tail.valid) begin
          res_next     = '0;
          wr_pend_next = '0;
          src_next     = probe_src;
          cand_next    = {1'b0, eph_min};
          inj_cnt_next = '0;
          ret_cnt_next = '0;
          found_next   = 1'b0;
          unique case (item.opcode)
            OP_OPEN: begin
              if (tail.hit) begin
                res_next.result_id = tail.hit_idx[3:0];
                wr_pend_next.en    = 1'b1;
                wr_pend_next.kind  = WR_OPEN;
                wr_pend_next.idx   = tail.hit_idx;
              end else begin
                res_next.status = ST_FULL;
              end
            end
            OP_CLOSE: begin
              if (tail.id_open) begin
                wr_pend_next.en   = 1'b1;
                wr_pend_next.kind = WR_CLOSE;
                wr_pend_next.idx  = {{(SLOT_W-4){1'b0}}, item.socket_id};
              end else begin
                res_next.status = ST_BAD_ID;
              end
            end
            OP_BIND: begin
              if (!tail.id_open) begin
                res_next.status = ST_BAD_ID;
              end else if (tail.hit) begin
                res_next.status = ST_IN_USE;
              end else begin
                wr_pend_next.en   = 1'b1;
                wr_pend_next.kind = WR_BIND;
                wr_pend_next.idx  = {{(SLOT_W-4){1'b0}}, item.socket_id};
                wr_pend_next.addr = item.ip_address;
                wr_pend_next.port = item.port_number;
              end
            end
            OP_LOOKUP: begin
              if (tail.hit) begin
                res_next.result_id = tail.hit_idx[3:0];
              end else begin
                res_next.status = ST_NO_MATCH;
              end
            end
            OP_PREP: begin
              if (!tail.id_open) begin
                res_next.status = ST_BAD_ID;
              end else if (probe_src == 32'd0) begin
                res_next.status = ST_NO_ROUTE;
              end else if (tail.id_port != 16'd0) begin
                res_next.local_address = probe_src;
                res_next.local_port    = tail.id_port;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // Feed one candidate port per cycle; answers come back in order.
        if (can_inject) begin
          head_next.valid = 1'b1;
          head_next.addr  = src;
          head_next.port  = cand[15:0];
          cand_next       = cand + 17'd1;
          inj_cnt_next    = inj_cnt + 1'b1;
        end
        if (tail.valid) begin
          ret_cnt_next = ret_cnt + 1'b1;
          if (!found && !tail.hit) begin
            found_next  = 1'b1;
            chosen_next = tail.port;
          end
        end
        if (scan_done) begin
          res_next = '0;
          if (found && chosen != 16'd0) begin
            res_next.local_address = src;
            res_next.local_port    = chosen;
            wr_pend_next.en        = 1'b1;
            wr_pend_next.kind      = WR_PORT;
            wr_pend_next.idx       = {{(SLOT_W-4){1'b0}}, item.socket_id};
            wr_pend_next.port      = chosen;
          end else begin
            res_next.status = ST_NO_PORT;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          wr       = wr_pend;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      head      <= '0;
      wr_pend   <= '0;
      eph_min   <= EPH_MIN_RESET;
      eph_max   <= EPH_MAX_RESET;
    end else begin
      state   <= state_next;
      head    <= head_next;
      wr_pend <= wr_pend_next;
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_EPH_MIN: eph_min <= cfg_data;
          CFG_EPH_MAX: eph_max <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    item    <= item_next;
    src     <= src_next;
    cand    <= cand_next;
    inj_cnt <= inj_cnt_next;
    ret_cnt <= ret_cnt_next;
    found   <= found_next;
    chosen  <= chosen_next;
    res     <= res_next;
    if (out_load) begin
      rsp <= res;
    end
  end

endmodule
